// File: rtl/cplm_pkg.sv
package cplm_pkg;

  localparam int CHAR_W       = 8;
  localparam int INDEX_W      = 10;
  localparam int LEN_W        = 3;
  localparam int ENTITY_W     = 9;
  localparam int PREFIX_CHARS = 4;
  localparam int PIDX_W       = $clog2(PREFIX_CHARS);
  // part lengths saturate one above the longest prefix
  localparam int COUNT_SAT    = PREFIX_CHARS + 1;
  localparam int TAIL_SHORT   = 2;
  localparam int HEAD_SHORT   = 3;

  localparam logic [CHAR_W-1:0] SLASH_CHAR  = 8'd47;
  localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHAR  = 1'b1;

  // queued operation kinds
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PREFIX_CHARS-1:0][CHAR_W-1:0] chars_t;

  typedef struct packed {
    logic [ENTITY_W-1:0] entity;
    logic [LEN_W-1:0]    len;
    chars_t              chars;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // lookup: entry.chars is the key, entry.len the key length
  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
    entry_t             entry;
  } op_t;

endpackage

// File: rtl/cplm_if.sv
interface cplm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [cplm_pkg::INDEX_W-1:0]      entry_index;
  logic [cplm_pkg::CHAR_W-1:0]       entry_char0;
  logic [cplm_pkg::CHAR_W-1:0]       entry_char1;
  logic [cplm_pkg::CHAR_W-1:0]       entry_char2;
  logic [cplm_pkg::CHAR_W-1:0]       entry_char3;
  logic [cplm_pkg::LEN_W-1:0]        entry_length;
  logic [cplm_pkg::ENTITY_W-1:0]     entry_entity;
  logic [cplm_pkg::CHAR_W-1:0]       call_char;
  logic                              call_last;

  modport source (
    output valid, command, entry_index, entry_char0, entry_char1, entry_char2,
           entry_char3, entry_length, entry_entity, call_char, call_last,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_char0, entry_char1, entry_char2,
           entry_char3, entry_length, entry_entity, call_char, call_last,
    output ready
  );
endinterface

interface cplm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [cplm_pkg::ENTITY_W-1:0] entity_code;
  logic [cplm_pkg::LEN_W-1:0]    matched_length;

  modport source (output valid, found, entity_code, matched_length, input ready);
  modport sink   (input valid, found, entity_code, matched_length, output ready);
endinterface

// File: rtl/cplm_ram.sv
module cplm_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cplm_front.sv
module cplm_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  cplm_in_if.sink       item,
  input  logic          hold,
  output cplm_pkg::op_t op,
  output logic          op_valid,
  input  logic          op_ready
);
  import cplm_pkg::*;

  chars_t           head_chars, tail_chars;
  logic [LEN_W-1:0] head_count, tail_count;
  logic             slash_seen;

  chars_t           head_chars_next, tail_chars_next, key_raw;
  logic [LEN_W-1:0] head_count_next, tail_count_next, key_len;
  logic             slash_seen_next, use_head, accept, in_range;
  chars_t           key;
  logic [LEN_W-1:0] wr_len;

  assign item.ready = !hold && op_ready;
  assign accept     = item.valid && item.ready;
  assign in_range   = 32'(item.entry_index) < 32'(TABLE_DEPTH);

  always_comb begin
    head_chars_next = head_chars;
    head_count_next = head_count;
    tail_chars_next = tail_chars;
    tail_count_next = tail_count;
    slash_seen_next = slash_seen;
    if (!slash_seen && item.call_char == SLASH_CHAR) begin
      slash_seen_next = 1'b1;
    end else if (!slash_seen) begin
      if (head_count < LEN_W'(PREFIX_CHARS)) begin
        head_chars_next[head_count[PIDX_W-1:0]] = item.call_char;
      end
      if (head_count < LEN_W'(COUNT_SAT)) begin
        head_count_next = head_count + 1'b1;
      end
    end else begin
      if (tail_count < LEN_W'(PREFIX_CHARS)) begin
        tail_chars_next[tail_count[PIDX_W-1:0]] = item.call_char;
      end
      if (tail_count < LEN_W'(COUNT_SAT)) begin
        tail_count_next = tail_count + 1'b1;
      end
    end

    use_head = !slash_seen_next || tail_count_next <= LEN_W'(TAIL_SHORT)
               || head_count_next <= LEN_W'(HEAD_SHORT);
    key_raw  = use_head ? head_chars_next : tail_chars_next;
    key_len  = use_head ? head_count_next : tail_count_next;
    for (int k = 0; k < PREFIX_CHARS; k++) begin
      if (key_raw[k] >= LOWER_A && key_raw[k] <= LOWER_Z) begin
        key[k] = key_raw[k] - CASE_OFFSET;
      end else begin
        key[k] = key_raw[k];
      end
    end

    // an overlong length leaves the slot empty
    wr_len = (item.entry_length > LEN_W'(PREFIX_CHARS)) ? '0 : item.entry_length;

    if (item.command == CMD_WRITE) begin
      op.kind         = OP_WRITE;
      op.index        = item.entry_index;
      op.entry.entity = item.entry_entity;
      op.entry.len    = wr_len;
      op.entry.chars  = {item.entry_char3, item.entry_char2,
                         item.entry_char1, item.entry_char0};
      op_valid        = accept && in_range;
    end else begin
      op.kind         = OP_LOOKUP;
      op.index        = '0;
      op.entry.entity = '0;
      op.entry.len    = key_len;
      op.entry.chars  = key;
      op_valid        = accept && item.call_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_chars <= '0;
      tail_chars <= '0;
      head_count <= '0;
      tail_count <= '0;
      slash_seen <= 1'b0;
    end else if (accept && item.command == CMD_CHAR) begin
      if (item.call_last) begin
        head_chars <= '0;
        tail_chars <= '0;
        head_count <= '0;
        tail_count <= '0;
        slash_seen <= 1'b0;
      end else begin
        head_chars <= head_chars_next;
        tail_chars <= tail_chars_next;
        head_count <= head_count_next;
        tail_count <= tail_count_next;
        slash_seen <= slash_seen_next;
      end
    end
  end

endmodule

// File: rtl/cplm_queue.sv
module cplm_queue (
  input  logic          clk,
  input  logic          rst,
  input  cplm_pkg::op_t in_op,
  input  logic          in_valid,
  output logic          in_ready,
  output cplm_pkg::op_t out_op,
  output logic          out_valid,
  input  logic          out_ready
);
  import cplm_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_op    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_op;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/cplm_back.sv
module cplm_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  cplm_pkg::op_t op,
  input  logic          op_valid,
  output logic          op_ready,
  output logic          clearing,
  cplm_out_if.source    result
);
  import cplm_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]          state;
  logic [AW-1:0]       scan_addr;
  logic                issuing, cmp_valid;
  chars_t              key;
  logic [LEN_W-1:0]    key_len;
  logic                best_found;
  logic [LEN_W-1:0]    best_len;
  logic [ENTITY_W-1:0] best_entity;
  logic                res_valid, res_found;
  logic [ENTITY_W-1:0] res_entity;
  logic [LEN_W-1:0]    res_len;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  entry_t              slot;
  logic                hit, last_addr;

  cplm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  assign clearing              = state == ST_CLEAR;
  assign last_addr             = scan_addr == AW'(TABLE_DEPTH - 1);
  assign slot                  = entry_t'(ram_rdata);
  assign result.valid          = res_valid;
  assign result.found          = res_found;
  assign result.entity_code    = res_entity;
  assign result.matched_length = res_len;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_addr;
    ram_wdata = '0;
    op_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        op_ready = 1'b1;
        if (op_valid && op.kind == OP_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(op.index);
          ram_wdata = op.entry;
        end
      end
      default: begin
      end
    endcase
  end

  // strictly longer than the best so far, so ties keep the lowest slot
  always_comb begin
    hit = slot.len != '0 && slot.len <= key_len && slot.len > best_len;
    for (int k = 0; k < PREFIX_CHARS; k++) begin
      if (LEN_W'(k) < slot.len && slot.chars[k] != key[k]) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_addr <= '0;
      issuing   <= 1'b0;
      cmp_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // in the finish state the output register is handled by the load below
      if (result.valid && result.ready && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          scan_addr <= last_addr ? '0 : scan_addr + 1'b1;
          if (last_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (op_valid && op.kind == OP_LOOKUP) begin
            key         <= op.entry.chars;
            key_len     <= op.entry.len;
            best_found  <= 1'b0;
            best_len    <= '0;
            best_entity <= '0;
            scan_addr   <= '0;
            issuing     <= 1'b1;
            cmp_valid   <= 1'b0;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            scan_addr <= last_addr ? '0 : scan_addr + 1'b1;
            if (last_addr) begin
              issuing <= 1'b0;
            end
          end
          cmp_valid <= issuing;
          if (cmp_valid && hit) begin
            best_found  <= 1'b1;
            best_len    <= slot.len;
            best_entity <= slot.entity;
          end
          if (cmp_valid && !issuing) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_found  <= best_found;
            res_entity <= best_entity;
            res_len    <= best_len;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/callsign_prefix_longest_match.sv
// Callsign prefix lookup: longest-prefix match of a streamed callsign against
// a loaded table of 1 to 4 character prefixes, each carrying an entity code.
// Input channel (item): each transaction either writes one table slot
// (command 0) or delivers one callsign character (command 1). A transaction
// with call_last set closes the callsign and queues a lookup.
// Output channel (result): one transaction per callsign with found,
// entity_code and matched_length of the winning slot (zeros if none).
// Characters and table writes are taken one per cycle while the two-entry
// operation queue has room. A lookup scans every slot through the table
// RAM read port, one slot per cycle, and no further operation starts until
// the scan is done and its result is loaded.
// After reset the table is cleared by a sweep over every slot; item ready
// stays low during it.
// A result not taken by the receiver sits in the output register; table
// writes carry on behind it, and the next lookup scans but holds its result
// until the register is free, while the queue backs up into item.ready.
module callsign_prefix_longest_match #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic        clk,
  input logic        rst,
  cplm_in_if.sink    item,
  cplm_out_if.source result
);
  import cplm_pkg::*;

  // front end to queue
  op_t  fe_op;
  logic fe_valid, fe_ready;
  // queue to scan engine
  op_t  be_op;
  logic be_valid, be_ready;
  // table sweep in progress: hold the input
  logic clearing;

  // Character assembly, head/tail choice and case folding
  cplm_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .hold     (clearing),
    .op       (fe_op),
    .op_valid (fe_valid),
    .op_ready (fe_ready)
  );

  // Keeps table writes and lookups in order between the two halves
  cplm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_op     (fe_op),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .out_op    (be_op),
    .out_valid (be_valid),
    .out_ready (be_ready)
  );

  // Table RAM, clearing sweep, linear scan and output register
  cplm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (be_op),
    .op_valid (be_valid),
    .op_ready (be_ready),
    .clearing (clearing),
    .result   (result)
  );

endmodule
